>>> hdl/mre_pkg.sv
// Shared constants and action codes for the matrix multiply row engine.
package mre_pkg;

  localparam int IDX_W  = 4;   // row and column index fields
  localparam int SIZE_W = 5;   // active_size register
  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product of two elements
  localparam int ACC_W  = 36;  // up to 16 products, each at most 2^30 in magnitude
  localparam int SUM_W  = 40;  // emitted Q24.16 element

  localparam int IN_DATA_W  = 24;  // row, col, elem_value
  localparam int OUT_DATA_W = 48;  // out_col, out_value, padded to bytes

  typedef logic [1:0] action_t;

  localparam action_t ACT_WR_A = 2'd0;
  localparam action_t ACT_WR_B = 2'd1;
  localparam action_t ACT_ROW  = 2'd2;

  localparam logic [2:0] REG_ACTIVE_SIZE = 3'd0;

endpackage

>>> hdl/mre_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module mre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/matrix_multiply_row_engine.sv
// Row engine for C = A x B over Q8.8 elements, with A and B held in two RAMs.
// Element writes go straight to the RAMs; the engine accepts an item every cycle while idle.
// A row request of size n emits n items; each column's n products are read, multiplied
// and accumulated by the single shared multiply-accumulate unit, and its read/multiply/
// accumulate pipe drains before the next column starts. rst_n is synchronous, active
// low: it clears control state and sets active_size to 16; RAM contents are kept.
module matrix_multiply_row_engine
  import mre_pkg::*;
#(
  parameter int DIM_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  // input item channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row[3:0], col[7:4], elem_value[23:8]
  input  logic [1:0]            in_tuser,   // action[1:0]
  // result item channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_col[3:0], out_value[43:4], zero[47:44]
  output logic                  out_tlast
);

  localparam int DEPTH = DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIM   = (DIM_MAX < 16) ? DIM_MAX : 16;  // largest usable size

  localparam logic [6:0]        DIM_V = 7'(DIM_MAX);
  localparam logic [SIZE_W-1:0] LIM_V = SIZE_W'(LIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;  // accept items
  localparam logic [1:0] ST_RUN   = 2'd1;  // issue reads for one column
  localparam logic [1:0] ST_FLUSH = 2'd2;  // wait for the sum, then hand it to the output

  // flat RAM address of entry (r, c)
  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    logic [11:0] lin;
    lin = {8'b0, r} * 12'(DIM_MAX) + {8'b0, c};
    return lin[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Unpack the input item
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [ELEM_W-1:0] in_val;
  action_t           in_act;
  logic              in_acc;

  assign in_row = in_tdata[3:0];
  assign in_col = in_tdata[7:4];
  assign in_val = in_tdata[23:8];
  assign in_act = in_tuser;
  assign in_acc = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] active_size_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_SIZE[2])
                      ? {{(32-SIZE_W){1'b0}}, active_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_W'(16);
    end else if (cfg_wr && cfg_paddr[2] == REG_ACTIVE_SIZE[2]) begin
      active_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  // Effective size: zero reads as one, clamp to the store and to 16.
  logic [SIZE_W-1:0] n_eff;

  always_comb begin
    if (active_size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (active_size_r > LIM_V) begin
      n_eff = LIM_V;
    end else begin
      n_eff = active_size_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] nm1_r, nm1_nxt;

  logic in_range;
  logic start_row;
  logic push;
  logic acc_rdy_r;
  logic out_vld_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_range  = ({3'b0, in_row} < DIM_V) && ({3'b0, in_col} < DIM_V);
  assign start_row = in_acc && (in_act == ACT_ROW) && ({1'b0, in_row} < n_eff);
  // hand the finished sum over when the output register is empty or draining
  assign push      = (state_r == ST_FLUSH) && acc_rdy_r && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    nm1_nxt   = nm1_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_row) begin
          row_nxt   = in_row;
          nm1_nxt   = IDX_W'(n_eff - SIZE_W'(1));
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_r == nm1_r) begin
          k_nxt     = '0;
          state_nxt = ST_FLUSH;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (push) begin
          if (j_r == nm1_r) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      j_r     <= '0;
      k_r     <= '0;
      nm1_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      nm1_r   <= nm1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Element stores: written from the input channel, read A[row][k] and B[k][j]
  // ---------------------------------------------------------------------------
  logic [ELEM_W-1:0] a_rd;
  logic [ELEM_W-1:0] b_rd;
  logic [AW-1:0]     wr_addr;
  logic              a_we;
  logic              b_we;

  assign wr_addr = addr_of(in_row, in_col);
  assign a_we    = in_acc && (in_act == ACT_WR_A) && in_range;
  assign b_we    = in_acc && (in_act == ACT_WR_B) && in_range;

  mre_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (in_val),
    .raddr (addr_of(row_r, k_r)),
    .rdata (a_rd)
  );

  mre_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (in_val),
    .raddr (addr_of(k_r, j_r)),
    .rdata (b_rd)
  );

  // ---------------------------------------------------------------------------
  // Multiply-accumulate pipe: read data, product register, accumulator
  // ---------------------------------------------------------------------------
  logic              s1_vld_r, s1_first_r, s1_last_r;
  logic              s2_vld_r, s2_first_r, s2_last_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_vld_r   <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      acc_rdy_r  <= 1'b0;
    end else begin
      s1_vld_r   <= (state_r == ST_RUN);
      s1_first_r <= (k_r == '0);
      s1_last_r  <= (k_r == nm1_r);
      s2_vld_r   <= s1_vld_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      if (s2_vld_r && s2_last_r) begin
        acc_rdy_r <= 1'b1;
      end else if (push) begin
        acc_rdy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(a_rd) * $signed(b_rd));
    if (s2_vld_r) begin
      acc_r <= s2_first_r ? prod_ext : (acc_r + prod_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. At most 16 products of at most 2^30 each keep the sum within
  // 2^34, so the 40-bit saturation bound is never reached: sign-extend only.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] out_col_r;
  logic [SUM_W-1:0] out_val_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_col_r  <= j_r;
      out_val_r  <= {{(SUM_W-ACC_W){acc_r[ACC_W-1]}}, acc_r};
      out_last_r <= (j_r == nm1_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-SUM_W-IDX_W){1'b0}}, out_val_r, out_col_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= nm1_r))
    else $error("inner index ran past the active size");

  a_pipe_empty_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    acc_rdy_r |-> (!s1_vld_r && !s2_vld_r))
    else $error("sum marked ready while products are still in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_val_r) && $stable(out_col_r)))
    else $error("pending result overwritten");

  a_last_on_final_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |-> (out_col_r == nm1_r))
    else $error("last flag on a column other than the final one");

endmodule
